FILE: design/fcs_pkg.sv
// Package for the filter cleaning sequencer.
// Holds the phase and command codes, field widths and the shared state types.
// No dependencies.
`default_nettype none

package fcs_pkg;

    // Field widths.
    localparam int unsigned ActionW   = 2;
    localparam int unsigned PhaseW    = 3;
    localparam int unsigned EdgeW     = 4;
    localparam int unsigned SettleW   = 8;
    localparam int unsigned StuckW    = 16;
    localparam int unsigned SecondsW  = 32;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 32;

    // Commands carried with each input transaction.
    localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
    localparam logic [ActionW-1:0] ACT_START = 2'd1;
    localparam logic [ActionW-1:0] ACT_STOP  = 2'd2;

    // Sequencer phase codes.
    localparam logic [PhaseW-1:0] PH_STOPPED  = 3'd0;
    localparam logic [PhaseW-1:0] PH_STARTED  = 3'd1;
    localparam logic [PhaseW-1:0] PH_COUNTING = 3'd2;
    localparam logic [PhaseW-1:0] PH_SETTLING = 3'd3;
    localparam logic [PhaseW-1:0] PH_WAITING  = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] REG_EDGE_TARGET   = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_SETTLE_TICKS  = 2'd1;
    localparam logic [CfgIndexW-1:0] REG_STUCK_TICKS   = 2'd2;
    localparam logic [CfgIndexW-1:0] REG_CYCLE_SECONDS = 2'd3;

    // Configuration reset values.
    localparam logic [EdgeW-1:0]    EDGE_TARGET_RST   = 4'd10;
    localparam logic [SettleW-1:0]  SETTLE_TICKS_RST  = 8'd90;
    localparam logic [StuckW-1:0]   STUCK_TICKS_RST   = 16'd3000;
    localparam logic [SecondsW-1:0] CYCLE_SECONDS_RST = 32'd21600;

    typedef struct packed {
        logic [EdgeW-1:0]    edge_target;
        logic [SettleW-1:0]  settle_ticks;
        logic [StuckW-1:0]   stuck_ticks;
        logic [SecondsW-1:0] cycle_seconds;
    } cfg_t;

    typedef struct packed {
        logic [PhaseW-1:0]   phase;
        logic [EdgeW-1:0]    edge_count;
        logic [SettleW-1:0]  settle_count;
        logic [SecondsW-1:0] cycle_start;
        logic                prev_pin;
        logic                enable;
        logic                enable_prev;
        logic                check_armed;
        logic [StuckW-1:0]   stuck_count;
        logic                fault;
    } state_t;

endpackage

`default_nettype wire

FILE: design/fcs_cfg_regs.sv
// Configuration register bank of the filter cleaning sequencer.
// Depends on fcs_pkg for the register indexes, widths and reset values.
`default_nettype none

module fcs_cfg_regs (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [fcs_pkg::CfgIndexW-1:0]    cfg_index,
    input  wire  [fcs_pkg::CfgDataW-1:0]     cfg_data,
    output fcs_pkg::cfg_t                    cfg
);

    fcs_pkg::cfg_t cfg_reg;
    fcs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                fcs_pkg::REG_EDGE_TARGET: begin
                    cfg_next.edge_target = cfg_data[fcs_pkg::EdgeW-1:0];
                end
                fcs_pkg::REG_SETTLE_TICKS: begin
                    cfg_next.settle_ticks = cfg_data[fcs_pkg::SettleW-1:0];
                end
                fcs_pkg::REG_STUCK_TICKS: begin
                    cfg_next.stuck_ticks = cfg_data[fcs_pkg::StuckW-1:0];
                end
                fcs_pkg::REG_CYCLE_SECONDS: begin
                    cfg_next.cycle_seconds = cfg_data[fcs_pkg::SecondsW-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_target   <= fcs_pkg::EDGE_TARGET_RST;
            cfg_reg.settle_ticks  <= fcs_pkg::SETTLE_TICKS_RST;
            cfg_reg.stuck_ticks   <= fcs_pkg::STUCK_TICKS_RST;
            cfg_reg.cycle_seconds <= fcs_pkg::CYCLE_SECONDS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/fcs_step.sv
// Next-state logic of the filter cleaning sequencer for one command or tick.
// Depends on fcs_pkg for the state and configuration types and the codes.
`default_nettype none

module fcs_step (
    input  fcs_pkg::state_t                  cur,
    input  fcs_pkg::cfg_t                    cfg,
    input  wire  [fcs_pkg::ActionW-1:0]      action,
    input  wire                              pin,
    input  wire  [fcs_pkg::SecondsW-1:0]     now,
    output fcs_pkg::state_t                  nxt
);

    always_comb begin
        fcs_pkg::state_t st;
        logic                          ref_pin;
        logic [fcs_pkg::SecondsW-1:0]  elapsed;

        st      = cur;
        ref_pin = cur.prev_pin;
        elapsed = now - cur.cycle_start;

        unique case (action)
            fcs_pkg::ACT_TICK: begin
                // Sequencer phase update.
                unique case (cur.phase)
                    fcs_pkg::PH_STARTED: begin
                        if (pin) begin
                            st.phase = fcs_pkg::PH_COUNTING;
                        end
                    end
                    fcs_pkg::PH_COUNTING: begin
                        if (pin && !cur.prev_pin) begin
                            st.edge_count = cur.edge_count + 1'b1;
                            if (st.edge_count == cfg.edge_target) begin
                                st.edge_count = '0;
                                st.phase      = fcs_pkg::PH_SETTLING;
                            end
                        end
                    end
                    fcs_pkg::PH_SETTLING: begin
                        st.settle_count = cur.settle_count + 1'b1;
                        if (st.settle_count >= cfg.settle_ticks) begin
                            st.settle_count = '0;
                            st.enable       = 1'b0;
                            st.phase        = fcs_pkg::PH_WAITING;
                            st.cycle_start  = now;
                        end
                    end
                    fcs_pkg::PH_WAITING: begin
                        if (elapsed == cfg.cycle_seconds) begin
                            st.phase  = fcs_pkg::PH_COUNTING;
                            st.enable = 1'b1;
                        end
                    end
                    default: begin
                        st.phase = cur.phase;
                    end
                endcase

                // Stuck-sensor watchdog, evaluated on the updated phase and enable.
                if (st.phase != fcs_pkg::PH_STOPPED) begin
                    if (st.enable && !cur.enable_prev) begin
                        st.stuck_count = '0;
                        st.check_armed = 1'b1;
                        ref_pin        = pin;
                    end else if (!st.enable) begin
                        st.stuck_count = '0;
                        st.check_armed = 1'b0;
                    end
                    st.enable_prev = st.enable;
                    if (st.check_armed) begin
                        if (pin != ref_pin) begin
                            st.stuck_count = '0;
                        end else begin
                            st.stuck_count = st.stuck_count + 1'b1;
                            if (st.stuck_count >= cfg.stuck_ticks) begin
                                st.stuck_count = '0;
                                st.fault       = 1'b1;
                            end
                        end
                    end
                end else begin
                    st.check_armed = 1'b0;
                    st.enable_prev = 1'b0;
                end
                st.prev_pin = pin;
            end
            fcs_pkg::ACT_START: begin
                st.phase  = fcs_pkg::PH_STARTED;
                st.enable = 1'b1;
            end
            fcs_pkg::ACT_STOP: begin
                st.edge_count   = '0;
                st.settle_count = '0;
                st.fault        = 1'b0;
                st.phase        = fcs_pkg::PH_STOPPED;
                st.enable       = 1'b0;
            end
            default: begin
                st = cur;
            end
        endcase

        nxt = st;
    end

endmodule

`default_nettype wire

FILE: design/filter_cleaning_sequencer.sv
// Top level of the filter cleaning sequencer: stream ports, input and result
// registers, sequencer state. Depends on fcs_pkg, fcs_cfg_regs and fcs_step.
`default_nettype none

// The sequencer takes one transaction per cycle on its input stream and returns
// exactly one result transaction for each, in order. A transaction is a start
// command, a stop command or a tick (tuser selects which); a tick carries the
// sensor pin level and the running seconds count in tdata. Each result reports
// the drive enable, the sticky stuck-sensor fault and the phase as they stand
// after that transaction. An accepted transaction is held in an input register,
// the next state is formed by shallow combinational compare and count logic,
// and the result lands in an output register at the first edge on which the
// result slot is free; the sustained rate is one transaction per cycle while
// the result stream does not stall. The loop that limits this rate is the
// update of the sequencer state register from its own value. While the result
// register is full and not taken, the input register still accepts one more
// transaction. The configuration registers are written through their own
// channel, which is always ready, and should only be changed while the block
// has no transaction in flight.

module filter_cleaning_sequencer (
    input  wire                              aclk,
    input  wire                              aresetn,

    // Input stream.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [39:0]                      s_tdata,   // [0] sensor_pin, [32:1] seconds_now
    input  wire  [1:0]                       s_tuser,   // [1:0] action

    // Result stream.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // [0] drive_enable, [1] fault,
                                                        // [4:2] phase

    // Configuration write channel.
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [fcs_pkg::CfgIndexW-1:0]    cfg_index,
    input  wire  [fcs_pkg::CfgDataW-1:0]     cfg_data
);

    fcs_pkg::cfg_t   cfg;
    fcs_pkg::state_t state_reg;
    fcs_pkg::state_t state_next;

    // Input register.
    logic                           in_vld_reg;
    logic [fcs_pkg::ActionW-1:0]    in_action_reg;
    logic                           in_pin_reg;
    logic [fcs_pkg::SecondsW-1:0]   in_now_reg;

    // Result register.
    logic                           out_vld_reg;
    logic                           out_enable_reg;
    logic                           out_fault_reg;
    logic [fcs_pkg::PhaseW-1:0]     out_phase_reg;

    logic out_free;
    logic advance;
    logic in_take;

    fcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcs_step u_step (
        .cur    (state_reg),
        .cfg    (cfg),
        .action (in_action_reg),
        .pin    (in_pin_reg),
        .now    (in_now_reg),
        .nxt    (state_next)
    );

    // The result slot frees up when it is empty or being taken this cycle.
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_phase_reg, out_fault_reg, out_enable_reg};

    // Input register control and payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg <= s_tuser;
            in_pin_reg    <= s_tdata[0];
            in_now_reg    <= s_tdata[32:1];
        end
    end

    // Sequencer state advances once per transaction that moves to the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_enable_reg <= state_next.enable;
            out_fault_reg  <= state_next.fault;
            out_phase_reg  <= state_next.phase;
        end
    end

    // The drive is enabled exactly in the started, counting and settling phases.
    a_enable_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.enable == (state_reg.phase == fcs_pkg::PH_STARTED ||
                             state_reg.phase == fcs_pkg::PH_COUNTING ||
                             state_reg.phase == fcs_pkg::PH_SETTLING))
        else $error("drive enable disagrees with sequencer phase");

    // A stop command that completes leaves the sequencer stopped with no fault.
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_action_reg == fcs_pkg::ACT_STOP) |=>
            (state_reg.phase == fcs_pkg::PH_STOPPED && !state_reg.fault &&
             !state_reg.enable))
        else $error("stop command did not clear the sequencer");

    // A held input transaction is not dropped while the result slot is busy.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_free) |=> (in_vld_reg && $stable(in_action_reg)))
        else $error("pending input transaction lost under backpressure");

    // The phase never leaves its defined range.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase <= fcs_pkg::PH_WAITING)
        else $error("sequencer phase out of range");

endmodule

`default_nettype wire
